/* rtl/mpt_pkg.sv */
// Package for the multichannel pulse timer: command codes, field widths
// and the packed input item type shared by the input stage and the core.
// No dependencies.
package mpt_pkg;

  // Fixed field widths of one input item
  localparam int CMD_W  = 3;
  localparam int CHAN_W = 4;
  localparam int MS_W   = 32;
  localparam int IN_W   = CMD_W + CHAN_W + 1 + MS_W + MS_W;

  // Command codes; the remaining codes change nothing
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PULSE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_LEVEL  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CANCEL_ALL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ALL_OFF    = 3'd4;

  // One input item, packed
  typedef struct packed {
    logic [MS_W-1:0]   now_ms;
    logic [MS_W-1:0]   pulse_len;
    logic              level;
    logic [CHAN_W-1:0] channel;
    logic [CMD_W-1:0]  command;
  } item_t;

endpackage

/* rtl/mpt_in_stage.sv */
// Input register of the multichannel pulse timer: holds one accepted item
// until the core takes it. Depends on mpt_pkg.
module mpt_in_stage
  import mpt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,   // command, channel, level, pulse_len, now_ms
  input  logic            take,
  output logic            item_valid,
  output item_t           item
);

  // Accept when empty or when the held item moves on this cycle
  assign s_tready = !item_valid || take;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // Load the item; the packed layout matches tdata from the lowest bit up
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= item_t'(s_tdata);
    end
  end

endmodule

/* rtl/mpt_core.sv */
// Timer core of the multichannel pulse timer: jack levels, armed flags and
// end times, the per-item update and the result register. Depends on mpt_pkg.
module mpt_core
  import mpt_pkg::*;
#(
  parameter int PULSE_CHANNELS = 12,
  parameter int TIME_BITS      = 32,
  parameter int OUT_W          = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  item_t            item,
  output logic             take,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata   // output_levels, pulse_active
);

  localparam int LEV_W = PULSE_CHANNELS + 2;

  logic [LEV_W-1:0]          levels;
  logic [LEV_W-1:0]          levels_next;
  logic [PULSE_CHANNELS-1:0] armed;
  logic [PULSE_CHANNELS-1:0] armed_next;
  logic [TIME_BITS-1:0]      end_times      [PULSE_CHANNELS];
  logic [TIME_BITS-1:0]      end_times_next [PULSE_CHANNELS];
  logic [TIME_BITS-1:0]      now_t;
  logic [TIME_BITS-1:0]      dur_t;
  logic [TIME_BITS-1:0]      pulse_end;
  logic                      dur_zero;

  // Move the item into the result register when that register frees up
  assign take = item_valid && (!m_tvalid || m_tready);

  // Times at the counter width; one shared end-time adder
  assign now_t     = TIME_BITS'(item.now_ms);
  assign dur_t     = TIME_BITS'(item.pulse_len);
  assign pulse_end = now_t + dur_t;
  assign dur_zero  = (dur_t == '0);

  // Per-jack update
  for (genvar j = 0; j < PULSE_CHANNELS; j++) begin : g_jack
    logic [TIME_BITS-1:0] diff;
    logic                 sel;

    assign diff = now_t - end_times[j];
    assign sel  = (32'(item.channel) == 32'(j));

    always_comb begin
      levels_next[j]    = levels[j];
      armed_next[j]     = armed[j];
      end_times_next[j] = end_times[j];
      unique case (item.command)
        CMD_TICK: begin
          // Expire when now - end is not negative
          if (armed[j] && !diff[TIME_BITS-1]) begin
            levels_next[j] = 1'b0;
            armed_next[j]  = 1'b0;
          end
        end
        CMD_PULSE: begin
          if (sel && !dur_zero && !armed[j]) begin
            levels_next[j]    = 1'b1;
            armed_next[j]     = 1'b1;
            end_times_next[j] = pulse_end;
          end
        end
        CMD_SET_LEVEL: begin
          if (sel) begin
            levels_next[j] = item.level;
          end
        end
        CMD_CANCEL_ALL: begin
          levels_next[j]    = 1'b0;
          armed_next[j]     = 1'b0;
          end_times_next[j] = '0;
        end
        CMD_ALL_OFF: begin
          levels_next[j] = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // LEDs follow set-level only
  for (genvar k = PULSE_CHANNELS; k < LEV_W; k++) begin : g_led
    always_comb begin
      levels_next[k] = levels[k];
      if (item.command == CMD_SET_LEVEL && 32'(item.channel) == 32'(k)) begin
        levels_next[k] = item.level;
      end
    end
  end

  // Commit state as the item passes
  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= '0;
      armed  <= '0;
    end else if (take) begin
      levels <= levels_next;
      armed  <= armed_next;
    end
  end

  // End times are only read while armed
  always_ff @(posedge clk) begin
    if (take) begin
      end_times <= end_times_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= OUT_W'({armed_next, levels_next});
    end
  end

endmodule

/* rtl/multichannel_pulse_timer.sv */
// Multichannel one-shot pulse timer, top level.
// Each item passes the input register, then the result register, before its result is valid.
// Throughput: one item per cycle while m_tready is high; each item yields one result.
// Reset (rst, synchronous, active high) drives all levels low, disarms all jacks
// and empties both registers. Depends on mpt_pkg, mpt_in_stage and mpt_core.
module multichannel_pulse_timer
  import mpt_pkg::*;
#(
  parameter int PULSE_CHANNELS = 12,
  parameter int TIME_BITS      = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // command, channel, level, pulse_len, now_ms
  input  logic [IN_W-1:0]                         s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // output_levels, pulse_active, zero fill
  output logic [((2*PULSE_CHANNELS+2+7)/8)*8-1:0] m_tdata
);

  localparam int OUT_W = ((2 * PULSE_CHANNELS + 2 + 7) / 8) * 8;

  logic  item_valid;
  logic  take;
  item_t item;

  // Input register
  mpt_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Timer state, update and result register
  mpt_core #(
    .PULSE_CHANNELS (PULSE_CHANNELS),
    .TIME_BITS      (TIME_BITS),
    .OUT_W          (OUT_W)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
